// File: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: expression does not hold");

// Check that a condition leads to a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication does not hold");

// Check that a condition leads to a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication does not hold");

`endif

// File: sv/svg_pkg.sv
// ----------------------------------------------------------------------------
// svg_pkg
// Shared widths, register indexes and types of the sphere vertex generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package svg_pkg;

   localparam int COUNT_WIDTH   = 9;
   localparam int DIVISOR_WIDTH = COUNT_WIDTH + 1;
   localparam int QUOT_WIDTH    = 17;
   localparam int DIV_WIDTH     = 27;
   localparam int TEX_SHIFT     = 17;
   localparam int MIN_SLICES    = 3;
   localparam int MIN_STACKS    = 2;
   localparam int ROUND_HALF    = 16384;
   localparam int WAVE_MAX      = 32767;

   typedef longint unsigned ulong_type;

   localparam ulong_type HALF_PI_Q30 = 64'd1686629713;
   localparam longint    ONE_Q30     = 64'sd1073741824;

   typedef logic [1:0]             csr_index_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic signed [15:0]     wave_type;

   localparam csr_index_type REG_RADIUS      = 2'd0;
   localparam csr_index_type REG_SLICE_COUNT = 2'd1;
   localparam csr_index_type REG_STACK_COUNT = 2'd2;

endpackage

`default_nettype wire

// File: sv/sphere_vertex_generator_unit.sv
// Sustains one word per cycle while rsp_ready does not stall the output.
// Depth is set by an input register, the 17-stage restoring dividers for angles and
// texture coordinates, then one stage per table lookup, normal and position product.
// A stalled rsp_ready freezes the whole pipeline; req_ready follows it directly.
// Synchronous reset empties the pipeline and loads radius 1.0 and counts of 16.
// ----------------------------------------------------------------------------
// sphere_vertex_generator_unit
// UV sphere vertex generator: normal, position, texture and vertex number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sphere_vertex_generator_unit #(
   parameter int MAX_DIVISIONS    = 256,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  svg_pkg::csr_index_type      csr_index,
   input  logic [15:0]                 csr_write_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [8:0]                  req_stack_index,
   input  logic [8:0]                  req_slice_index,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [15:0]          rsp_normal_x,
   output logic signed [15:0]          rsp_normal_y,
   output logic signed [15:0]          rsp_normal_z,
   output logic signed [16:0]          rsp_pos_x,
   output logic signed [16:0]          rsp_pos_y,
   output logic signed [16:0]          rsp_pos_z,
   output logic [16:0]                 rsp_tex_u,
   output logic [16:0]                 rsp_tex_v,
   output logic [16:0]                 rsp_vertex_number,
   output logic                        rsp_out_of_range
);
   import svg_pkg::*;

   localparam int AngleWidth = $clog2(SINE_TABLE_DEPTH);

   typedef struct packed {
      logic        flag;
      logic [16:0] vertex;
   } side_type;

   typedef struct packed {
      logic        flag;
      logic [16:0] vertex;
      logic [16:0] tex_u;
      logic [16:0] tex_v;
   } tail_type;

   function automatic logic signed [16:0] mul_round15(input logic signed [16:0] a,
                                                       input logic signed [16:0] b);
      logic        neg;
      logic [16:0] ma;
      logic [16:0] mb;
      logic [33:0] prod;
      neg  = a[16] ^ b[16];
      ma   = a[16] ? 17'(-a) : a;
      mb   = b[16] ? 17'(-b) : b;
      prod = ma * mb + 34'(ROUND_HALF);
      return neg ? 17'(-prod[31:15]) : prod[31:15];
   endfunction

   // configuration
   logic [15:0] radius_ff;
   count_type   slice_count_ff;
   count_type   stack_count_ff;
   count_type   sc;
   count_type   tc;

   // pipeline control
   logic advance;

   // input stage
   logic      valid1_ff;
   count_type stack_ff;
   count_type slice_ff;

   count_type                stack_clamp;
   count_type                slice_clamp;
   side_type                 side_in;
   logic [DIV_WIDTH-1:0]     az_dividend;
   logic [DIV_WIDTH-1:0]     pol_dividend;
   logic [DIV_WIDTH-1:0]     u_dividend;
   logic [DIV_WIDTH-1:0]     v_dividend;
   logic [DIVISOR_WIDTH-1:0] sc_divisor;
   logic [DIVISOR_WIDTH-1:0] tc_divisor;
   logic [18:0]              vertex_prod;

   // divider stages
   logic [QUOT_WIDTH-1:0] valid_div_ff;
   side_type              side_ff [QUOT_WIDTH];
   logic [QUOT_WIDTH-1:0] az_quot;
   logic [QUOT_WIDTH-1:0] pol_quot;
   logic [QUOT_WIDTH-1:0] u_quot;
   logic [QUOT_WIDTH-1:0] v_quot;

   // table stage
   logic     valid_wave_ff;
   tail_type wave_tail_ff;
   wave_type az_sine;
   wave_type az_cosine;
   wave_type pol_sine;
   wave_type pol_cosine;

   // normal stage
   logic              valid_norm_ff;
   tail_type          norm_tail_ff;
   logic signed [15:0] nx_ff;
   logic signed [15:0] ny_ff;
   logic signed [15:0] nz_ff;

   // output stage
   logic              rsp_valid_ff;
   tail_type          out_tail_ff;
   logic signed [15:0] out_nx_ff;
   logic signed [15:0] out_ny_ff;
   logic signed [15:0] out_nz_ff;
   logic signed [16:0] pos_x_ff;
   logic signed [16:0] pos_y_ff;
   logic signed [16:0] pos_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff      <= 16'd256;
         slice_count_ff <= COUNT_WIDTH'(16);
         stack_count_ff <= COUNT_WIDTH'(16);
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_RADIUS:      radius_ff      <= csr_write_data;
            REG_SLICE_COUNT: slice_count_ff <= csr_write_data[COUNT_WIDTH-1:0];
            REG_STACK_COUNT: stack_count_ff <= csr_write_data[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (slice_count_ff < COUNT_WIDTH'(MIN_SLICES)) begin
         sc = COUNT_WIDTH'(MIN_SLICES);
      end else if (int'(slice_count_ff) > MAX_DIVISIONS) begin
         sc = COUNT_WIDTH'(MAX_DIVISIONS);
      end else begin
         sc = slice_count_ff;
      end
      if (stack_count_ff < COUNT_WIDTH'(MIN_STACKS)) begin
         tc = COUNT_WIDTH'(MIN_STACKS);
      end else if (int'(stack_count_ff) > MAX_DIVISIONS) begin
         tc = COUNT_WIDTH'(MAX_DIVISIONS);
      end else begin
         tc = stack_count_ff;
      end
   end

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff     <= 1'b0;
         valid_div_ff  <= '0;
         valid_wave_ff <= 1'b0;
         valid_norm_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         valid1_ff     <= req_valid;
         valid_div_ff  <= {valid_div_ff[QUOT_WIDTH-2:0], valid1_ff};
         valid_wave_ff <= valid_div_ff[QUOT_WIDTH-1];
         valid_norm_ff <= valid_wave_ff;
         rsp_valid_ff  <= valid_norm_ff;
      end
   end

   // clamp indices and form the rounded-ratio dividends
   always_comb begin
      stack_clamp = (stack_ff > tc) ? tc : stack_ff;
      slice_clamp = (slice_ff > sc) ? sc : slice_ff;
      sc_divisor  = {sc, 1'b0};
      tc_divisor  = {tc, 1'b0};
      az_dividend  = (DIV_WIDTH'(slice_clamp) << (AngleWidth + 1)) + DIV_WIDTH'(sc);
      pol_dividend = (DIV_WIDTH'(stack_clamp) << AngleWidth) + DIV_WIDTH'(tc);
      u_dividend   = (DIV_WIDTH'(slice_clamp) << TEX_SHIFT) + DIV_WIDTH'(sc);
      v_dividend   = (DIV_WIDTH'(stack_clamp) << TEX_SHIFT) + DIV_WIDTH'(tc);
      vertex_prod  = ({1'b0, sc} + 10'd1) * stack_clamp;
      side_in.flag   = (stack_ff > tc) || (slice_ff > sc);
      side_in.vertex = 17'(vertex_prod + 19'(slice_clamp));
   end

   svg_divider u_div_az (
      .clock    (clock),
      .advance  (advance),
      .dividend (az_dividend),
      .divisor  (sc_divisor),
      .quotient (az_quot)
   );

   svg_divider u_div_pol (
      .clock    (clock),
      .advance  (advance),
      .dividend (pol_dividend),
      .divisor  (tc_divisor),
      .quotient (pol_quot)
   );

   svg_divider u_div_u (
      .clock    (clock),
      .advance  (advance),
      .dividend (u_dividend),
      .divisor  (sc_divisor),
      .quotient (u_quot)
   );

   svg_divider u_div_v (
      .clock    (clock),
      .advance  (advance),
      .dividend (v_dividend),
      .divisor  (tc_divisor),
      .quotient (v_quot)
   );

   // angle quotients wrap to the table depth
   svg_wave #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_wave (
      .clock      (clock),
      .advance    (advance),
      .az_index   (az_quot[AngleWidth-1:0]),
      .pol_index  (pol_quot[AngleWidth-1:0]),
      .az_sine    (az_sine),
      .az_cosine  (az_cosine),
      .pol_sine   (pol_sine),
      .pol_cosine (pol_cosine)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         stack_ff   <= req_stack_index;
         slice_ff   <= req_slice_index;
         side_ff[0] <= side_in;
         for (int s = 1; s < QUOT_WIDTH; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         wave_tail_ff.flag   <= side_ff[QUOT_WIDTH-1].flag;
         wave_tail_ff.vertex <= side_ff[QUOT_WIDTH-1].vertex;
         wave_tail_ff.tex_u  <= u_quot;
         wave_tail_ff.tex_v  <= v_quot;
         norm_tail_ff <= wave_tail_ff;
         nx_ff <= 16'(mul_round15({az_cosine[15], az_cosine}, {pol_sine[15], pol_sine}));
         ny_ff <= pol_cosine;
         nz_ff <= 16'(mul_round15({az_sine[15], az_sine}, {pol_sine[15], pol_sine}));
         out_tail_ff <= norm_tail_ff;
         out_nx_ff   <= nx_ff;
         out_ny_ff   <= ny_ff;
         out_nz_ff   <= nz_ff;
         pos_x_ff    <= mul_round15({nx_ff[15], nx_ff}, {1'b0, radius_ff});
         pos_y_ff    <= mul_round15({ny_ff[15], ny_ff}, {1'b0, radius_ff});
         pos_z_ff    <= mul_round15({nz_ff[15], nz_ff}, {1'b0, radius_ff});
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_normal_x      = out_nx_ff;
   assign rsp_normal_y      = out_ny_ff;
   assign rsp_normal_z      = out_nz_ff;
   assign rsp_pos_x         = pos_x_ff;
   assign rsp_pos_y         = pos_y_ff;
   assign rsp_pos_z         = pos_z_ff;
   assign rsp_tex_u         = out_tail_ff.tex_u;
   assign rsp_tex_v         = out_tail_ff.tex_v;
   assign rsp_vertex_number = out_tail_ff.vertex;
   assign rsp_out_of_range  = out_tail_ff.flag;

endmodule

`default_nettype wire

// File: sv/svg_divider.sv
// ----------------------------------------------------------------------------
// svg_divider
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svg_divider (
   input  logic                                clock,
   input  logic                                advance,
   input  logic [svg_pkg::DIV_WIDTH-1:0]       dividend,
   input  logic [svg_pkg::DIVISOR_WIDTH-1:0]   divisor,
   output logic [svg_pkg::QUOT_WIDTH-1:0]      quotient
);
   import svg_pkg::*;

   logic [DIV_WIDTH-1:0]     rem_ff [QUOT_WIDTH];
   logic [DIV_WIDTH-1:0]     rem_in [QUOT_WIDTH];
   logic [DIVISOR_WIDTH-1:0] den_ff [QUOT_WIDTH];
   logic [DIVISOR_WIDTH-1:0] den_in [QUOT_WIDTH];
   logic [QUOT_WIDTH-1:0]    quo_ff [QUOT_WIDTH];
   logic [QUOT_WIDTH-1:0]    quo_in [QUOT_WIDTH];

   always_comb begin
      logic [DIV_WIDTH-1:0]     prev_rem;
      logic [DIV_WIDTH-1:0]     trial;
      logic [DIVISOR_WIDTH-1:0] prev_den;
      logic [QUOT_WIDTH-1:0]    prev_quo;
      for (int s = 0; s < QUOT_WIDTH; s++) begin
         if (s == 0) begin
            prev_rem = dividend;
            prev_den = divisor;
            prev_quo = '0;
         end else begin
            prev_rem = rem_ff[s-1];
            prev_den = den_ff[s-1];
            prev_quo = quo_ff[s-1];
         end
         // stage s decides quotient bit QUOT_WIDTH-1-s
         trial = DIV_WIDTH'(prev_den) << (QUOT_WIDTH - 1 - s);
         den_in[s] = prev_den;
         if (prev_rem >= trial) begin
            rem_in[s] = prev_rem - trial;
            quo_in[s] = prev_quo | (QUOT_WIDTH'(1) << (QUOT_WIDTH - 1 - s));
         end else begin
            rem_in[s] = prev_rem;
            quo_in[s] = prev_quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < QUOT_WIDTH; s++) begin
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= den_in[s];
            quo_ff[s] <= quo_in[s];
         end
      end
   end

   assign quotient = quo_ff[QUOT_WIDTH-1];

endmodule

`default_nettype wire

// File: sv/svg_wave.sv
// ----------------------------------------------------------------------------
// svg_wave
// Quarter-wave sine table and four registered sine/cosine lookups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svg_wave #(
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                advance,
   input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] az_index,
   input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] pol_index,
   output svg_pkg::wave_type                   az_sine,
   output svg_pkg::wave_type                   az_cosine,
   output svg_pkg::wave_type                   pol_sine,
   output svg_pkg::wave_type                   pol_cosine
);
   import svg_pkg::*;

   localparam int AngleWidth   = $clog2(SINE_TABLE_DEPTH);
   localparam int QuarterDepth = SINE_TABLE_DEPTH / 4;
   localparam int IndexWidth   = AngleWidth - 1;

   logic [14:0]           quarter [QuarterDepth+1];
   logic [AngleWidth-1:0] lane_idx [4];
   logic [IndexWidth-1:0] table_idx [4];
   logic [14:0]           mag [4];
   wave_type              wave_in [4];
   wave_type              wave_ff [4];

   // Taylor series of degree 13 in Q2.30, rounded half up to Q1.15
   for (genvar j = 0; j <= QuarterDepth; j++) begin : g_tab
      localparam ulong_type X  = (ulong_type'(4 * j) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      localparam ulong_type X2 = (X * X) >> 30;
      localparam ulong_type T1 = ((X * X2) >> 30) / 6;
      localparam ulong_type T2 = ((T1 * X2) >> 30) / 20;
      localparam ulong_type T3 = ((T2 * X2) >> 30) / 42;
      localparam ulong_type T4 = ((T3 * X2) >> 30) / 72;
      localparam ulong_type T5 = ((T4 * X2) >> 30) / 110;
      localparam ulong_type T6 = ((T5 * X2) >> 30) / 156;
      localparam longint S = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
                             + longint'(T4) - longint'(T5) + longint'(T6);
      localparam longint SC = (S < 0) ? 0 : ((S > ONE_Q30) ? ONE_Q30 : S);
      localparam longint MAG = (SC + ROUND_HALF) >>> 15;
      localparam longint MAGC = (MAG > WAVE_MAX) ? WAVE_MAX : MAG;
      assign quarter[j] = 15'(MAGC);
   end

   assign lane_idx[0] = az_index;
   assign lane_idx[1] = az_index + AngleWidth'(QuarterDepth);
   assign lane_idx[2] = pol_index;
   assign lane_idx[3] = pol_index + AngleWidth'(QuarterDepth);

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         table_idx[l] = {1'b0, lane_idx[l][AngleWidth-3:0]};
         // odd quadrants run the quarter wave backward
         if (lane_idx[l][AngleWidth-2]) begin
            table_idx[l] = IndexWidth'(QuarterDepth) - table_idx[l];
         end
         mag[l] = quarter[table_idx[l]];
         if (lane_idx[l][AngleWidth-1]) begin
            wave_in[l] = -wave_type'({1'b0, mag[l]});
         end else begin
            wave_in[l] = wave_type'({1'b0, mag[l]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < 4; l++) begin
            wave_ff[l] <= wave_in[l];
         end
      end
   end

   assign az_sine    = wave_ff[0];
   assign az_cosine  = wave_ff[1];
   assign pol_sine   = wave_ff[2];
   assign pol_cosine = wave_ff[3];

endmodule

`default_nettype wire

// File: sv/svg_checker.sv
// ----------------------------------------------------------------------------
// svg_checker
// Port-level checks of the sphere vertex generator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module svg_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_normal_x,
   input  logic signed [15:0] rsp_normal_y,
   input  logic signed [16:0] rsp_pos_x,
   input  logic [16:0]        rsp_tex_u,
   input  logic [16:0]        rsp_tex_v
);

   // a held word keeps its position x and texture u
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_pos_x) && $stable(rsp_tex_u))

   // input side stalls exactly when a result word is stuck
   `ASSERT_ALWAYS(a_ready_follows_output, clock, reset,
      req_ready == (!rsp_valid || rsp_ready))

   // clamped indices keep texture coordinates at or below one
   `ASSERT_IMPLIES(a_tex_bound, clock, reset, rsp_valid,
      rsp_tex_u <= 17'd65536 && rsp_tex_v <= 17'd65536)

   // the wave table saturates at +-32767
   `ASSERT_IMPLIES(a_normal_bound, clock, reset, rsp_valid,
      rsp_normal_x != 16'sh8000 && rsp_normal_y != 16'sh8000)

endmodule

bind sphere_vertex_generator_unit svg_checker u_svg_checker (.*);

`default_nettype wire
